### src/stf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_pkg
// shared constants of the scanline triangle fill block: command codes,
// register indexes, channel field widths and default sizes
// ----------------------------------------------------------------------------
package stf_pkg;

    // command codes
    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    // register reset values
    localparam logic [7:0] FRAME_WIDTH_RST  = 8'd128;
    localparam logic [6:0] FRAME_HEIGHT_RST = 7'd64;

    // default sizes
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_COORD_BITS = 11;

    // pixel color
    typedef logic [23:0] t_rgb;

endpackage

### src/stf_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_cmd_if
// command channel: draw, read or clear requests
// ----------------------------------------------------------------------------
interface stf_cmd_if #(
    parameter int COORD_BITS = 11
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic [7:0]                   fill_red;
    logic [7:0]                   fill_green;
    logic [7:0]                   fill_blue;
    logic [6:0]                   read_column;
    logic [5:0]                   read_row;

    modport source (
        output valid, func, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, fill_red, fill_green, fill_blue,
               read_column, read_row,
        input  ready
    );
    modport sink (
        input  valid, func, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, fill_red, fill_green, fill_blue,
               read_column, read_row,
        output ready
    );
endinterface

### src/stf_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_pix_if
// result channel: one pixel color per command
// ----------------------------------------------------------------------------
interface stf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue,
        input  ready
    );
    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue,
        output ready
    );
endinterface

### src/stf_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stf_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface stf_cfg_if
    import stf_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/scanline_triangle_fill_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_triangle_fill_top
// rgb frame store with triangle fill, pixel read and frame clear commands
// ----------------------------------------------------------------------------
//  channel  dir  request payload
//  i_cmd    in   func, three vertices, fill color, read column/row
//  o_pix    out  pixel_red, pixel_green, pixel_blue
//  i_cfg    in   register index, write data (frame_width, frame_height)
//
//  read: one pixel from the store; clear: all 2^(RB+CB) store words, one store word per cycle
//  draw: per visible row two serial restoring divides, then one store
//  write per covered pixel (single write port)
//  after reset a clearing pass over all 2^(RB+CB) store words (8192 at defaults) runs
//  before the first command is taken; config writes are taken at any time
//  a finished result waits in an output register while the next command runs
// ----------------------------------------------------------------------------
module scanline_triangle_fill_top
    import stf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input logic       i_clk,
    input logic       i_rst_n,
    stf_cmd_if.sink   i_cmd,
    stf_pix_if.source o_pix,
    stf_cfg_if.sink   i_cfg
);

    localparam int CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = CB + RB;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = COORD_BITS + 2;
    localparam int PW    = 2 * DW + 1;
    localparam int RW    = DW + 1;
    localparam int NB    = $clog2(PW + 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_ROW   = 4'd3;
    localparam logic [3:0] S_LDA   = 4'd4;
    localparam logic [3:0] S_LDB   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SETUP = 4'd7;
    localparam logic [3:0] S_SPAN  = 4'd8;
    localparam logic [3:0] S_RESP  = 4'd9;

    // control registers
    logic [3:0]    r_state;
    logic [7:0]    r_fw;
    logic [6:0]    r_fh;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_resp;
    logic          r_out_valid;
    logic          r_sel;
    logic [NB-1:0] r_cnt;

    // payload registers
    logic signed [DW-1:0]   r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [DW-1:0]   r_total, r_den_b, r_i, r_iend;
    logic signed [2*DW-1:0] r_pa1, r_pa2, r_pb1, r_pb2;
    logic signed [PW-1:0]   r_xa, r_xb;
    logic [PW-1:0]          r_num;
    logic [RW-1:0]          r_rem, r_dmag;
    logic                   r_neg;
    logic [CB-1:0]          r_x, r_x1;
    logic                   r_rd_hit;
    t_rgb                   r_color, r_res, r_out_rgb, r_rd;

    // frame store
    t_rgb mem [DEPTH];

    logic                 in_acc;
    logic                 out_acc;
    logic signed [DW-1:0] n_ay, n_cy, n_total, n_h_ay, n_istart, n_iend;
    logic [8:0]           n_w;
    logic [7:0]           n_h;
    logic [CB+6:0]        n_col_ext;
    logic [RB+5:0]        n_row_ext;
    logic [AW-1:0]        n_raddr;
    logic                 n_hit;
    logic signed [DW-1:0] n_dyab, n_seg, n_base, n_delta, n_inum, n_row;
    logic                 n_lower;
    logic signed [PW-1:0] n_dvd, n_q, n_lo, n_hi, n_x0, n_x1, n_wm1;
    logic signed [DW-1:0] n_dvs;
    logic [PW-1:0]        n_dvd_mag, n_qmag;
    logic [RW-1:0]        n_rem_sh;
    logic                 n_qbit;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    t_rgb                 mem_wdata;

    assign in_acc  = i_cmd.valid && i_cmd.ready;
    assign out_acc = o_pix.valid && o_pix.ready;

    // handshakes
    assign i_cmd.ready       = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_red   = r_out_rgb[23:16];
    assign o_pix.pixel_green = r_out_rgb[15:8];
    assign o_pix.pixel_blue  = r_out_rgb[7:0];

    // clipped frame sizes
    assign n_w = (32'(r_fw) > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {1'b0, r_fw};
    assign n_h = (32'(r_fh) > 32'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : {1'b0, r_fh};
    assign n_wm1 = $signed(PW'(n_w)) - PW'(1);

    // row range of a new draw
    assign n_ay     = DW'(i_cmd.vertex_a_y);
    assign n_cy     = DW'(i_cmd.vertex_c_y);
    assign n_total  = n_cy - n_ay;
    assign n_h_ay   = $signed(DW'(n_h)) - n_ay;
    assign n_istart = (n_ay < 0) ? -n_ay : '0;
    assign n_iend   = (n_total < n_h_ay) ? n_total : n_h_ay;

    // read address straight from the request
    assign n_col_ext = {{CB{1'b0}}, i_cmd.read_column};
    assign n_row_ext = {{RB{1'b0}}, i_cmd.read_row};
    assign n_raddr   = {n_row_ext[RB-1:0], n_col_ext[CB-1:0]};
    assign n_hit     = (32'(i_cmd.read_column) < 32'(MAX_WIDTH)) &&
                       (32'(i_cmd.read_row) < 32'(MAX_HEIGHT));

    // half selection and the other edge's terms for the current row
    assign n_dyab  = r_by - r_ay;
    assign n_lower = (r_i > n_dyab) || (r_by == r_ay);
    assign n_seg   = n_lower ? (r_cy - r_by) : n_dyab;
    assign n_base  = n_lower ? r_bx : r_ax;
    assign n_delta = n_lower ? (r_cx - r_bx) : (r_bx - r_ax);
    assign n_inum  = n_lower ? (r_i - n_dyab) : r_i;
    assign n_row   = r_ay + r_i;

    // divider operands
    assign n_dvd = (r_state == S_LDA) ? (PW'(r_pa1) + PW'(r_pa2))
                                      : (PW'(r_pb1) + PW'(r_pb2));
    assign n_dvs = (r_state == S_LDA) ? r_total : r_den_b;
    assign n_dvd_mag = n_dvd[PW-1] ? PW'(-n_dvd) : PW'(n_dvd);

    // one restoring divide step
    assign n_rem_sh = {r_rem[RW-2:0], r_num[PW-1]};
    assign n_qbit   = (n_rem_sh >= r_dmag);
    assign n_qmag   = {r_num[PW-2:0], n_qbit};
    assign n_q      = r_neg ? -$signed(n_qmag) : $signed(n_qmag);

    // span ends, ordered and clipped
    assign n_lo = (r_xa > r_xb) ? r_xb : r_xa;
    assign n_hi = (r_xa > r_xb) ? r_xa : r_xb;
    assign n_x0 = (n_lo < 0) ? '0 : n_lo;
    assign n_x1 = (n_hi < n_wm1) ? n_hi : n_wm1;

    // store write port
    assign mem_we    = (r_state == S_CLR) || (r_state == S_SPAN);
    assign mem_waddr = (r_state == S_CLR) ? r_clr_addr : {n_row[RB-1:0], r_x};
    assign mem_wdata = (r_state == S_CLR) ? '0 : r_color;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[n_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= FRAME_WIDTH_RST;
            r_fh <= FRAME_HEIGHT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == REG_FRAME_WIDTH) begin
                r_fw <= i_cfg.data;
            end else if (i_cfg.index == REG_FRAME_HEIGHT) begin
                r_fh <= i_cfg.data[6:0];
            end
        end
    end

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_resp  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (out_acc && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_res   <= '0;
                        r_state <= r_clr_resp ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_res <= '0;
                        unique case (i_cmd.func)
                            FUNC_DRAW: begin
                                r_ax    <= DW'(i_cmd.vertex_a_x);
                                r_ay    <= n_ay;
                                r_bx    <= DW'(i_cmd.vertex_b_x);
                                r_by    <= DW'(i_cmd.vertex_b_y);
                                r_cx    <= DW'(i_cmd.vertex_c_x);
                                r_cy    <= n_cy;
                                r_total <= n_total;
                                r_i     <= n_istart;
                                r_iend  <= n_iend;
                                r_color <= {i_cmd.fill_red, i_cmd.fill_green,
                                            i_cmd.fill_blue};
                                r_state <= S_ROW;
                            end
                            FUNC_READ: begin
                                r_rd_hit <= n_hit;
                                r_state  <= S_READ;
                            end
                            FUNC_CLEAR: begin
                                r_clr_addr <= '0;
                                r_clr_resp <= 1'b1;
                                r_state    <= S_CLR;
                            end
                            default: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_res   <= r_rd_hit ? r_rd : '0;
                    r_state <= S_RESP;
                end
                S_ROW: begin
                    if (r_i >= r_iend) begin
                        r_res   <= '0;
                        r_state <= S_RESP;
                    end else if (n_seg == '0) begin
                        r_i <= r_i + DW'(1);
                    end else begin
                        r_pa1   <= r_ax * r_total;
                        r_pa2   <= (r_cx - r_ax) * r_i;
                        r_pb1   <= n_base * n_seg;
                        r_pb2   <= n_delta * n_inum;
                        r_den_b <= n_seg;
                        r_state <= S_LDA;
                    end
                end
                S_LDA, S_LDB: begin
                    r_num   <= n_dvd_mag;
                    r_dmag  <= n_dvs[DW-1] ? RW'(-n_dvs) : RW'(n_dvs);
                    r_neg   <= n_dvd[PW-1] ^ n_dvs[DW-1];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_sel   <= (r_state == S_LDB);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_qbit ? (n_rem_sh - r_dmag) : n_rem_sh;
                    r_num <= n_qmag;
                    r_cnt <= r_cnt + NB'(1);
                    if (r_cnt == NB'(PW - 1)) begin
                        if (!r_sel) begin
                            r_xa    <= n_q;
                            r_state <= S_LDB;
                        end else begin
                            r_xb    <= n_q;
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    // both edge columns are registered by now
                    if (n_x0 <= n_x1) begin
                        r_x     <= n_x0[CB-1:0];
                        r_x1    <= n_x1[CB-1:0];
                        r_state <= S_SPAN;
                    end else begin
                        r_i     <= r_i + DW'(1);
                        r_state <= S_ROW;
                    end
                end
                S_SPAN: begin
                    if (r_x == r_x1) begin
                        r_i     <= r_i + DW'(1);
                        r_state <= S_ROW;
                    end else begin
                        r_x <= r_x + CB'(1);
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || out_acc) begin
                        r_out_valid <= 1'b1;
                        r_out_rgb   <= r_res;
                        r_clr_resp  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // edge columns are captured at the last step of each divide,
    // so SETUP works from r_xa and r_xb only

    // a taken request always leaves the idle state
    a_cmd_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("command accepted but sequencer stayed idle");

    // pixel walk never passes the right end of the span
    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPAN) |-> (r_x <= r_x1))
        else $error("span column beyond right end");

    // divider step count stays within the quotient width
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < NB'(PW)))
        else $error("divider ran past its last step");

    // no result is overwritten before it is taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pix.ready && (r_state == S_RESP)) |=> (r_state == S_RESP))
        else $error("pending result overwritten");

endmodule

### dv/tb_scanline_triangle_fill_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scanline_triangle_fill_top
// self-checking bench for the triangle fill frame store: a shadow frame
// store predicts every pixel read, commands and results see random idling
// on both channels, and the frame size registers are swept between phases
// ----------------------------------------------------------------------------
module tb_scanline_triangle_fill_top
    import stf_pkg::*;
;

    localparam int CB = DEF_COORD_BITS;
    localparam int STALL_LIMIT = 60000;

    typedef struct {
        logic [1:0]           func;
        logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
        logic [7:0]           red, green, blue;
        logic [6:0]           col;
        logic [5:0]           row;
    } t_cmd;

    // shadow frame store and expected pixel queue
    class pixel_scoreboard;
        t_rgb        shadow[DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
        logic [7:0]  width_reg;
        logic [6:0]  height_reg;
        t_rgb        pending[$];
        int          mismatches;
        int          reads_seen;

        function void reset_state();
            foreach (shadow[k]) shadow[k] = '0;
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_FRAME_WIDTH) width_reg = val;
            else if (idx == REG_FRAME_HEIGHT) height_reg = val[6:0];
        endfunction

        // edge column: base + delta*num/den truncated toward zero as a whole
        function longint edge_col(longint base, longint delta, longint num, longint den);
            return (base * den + delta * num) / den;
        endfunction

        function void fill_triangle(t_cmd c);
            longint ax, ay, bx, by, cx, cy, w, h, total, row, seg, xa, xb, tmp;
            bit lower;
            ax = c.ax; ay = c.ay; bx = c.bx; by = c.by; cx = c.cx; cy = c.cy;
            w = (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
            h = (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
            if (ay == cy) return;
            total = cy - ay;
            for (longint i = 0; i < total; i++) begin
                row = ay + i;
                if (row < 0 || row >= h) continue;
                lower = (i > by - ay) || (by == ay);
                seg = lower ? cy - by : by - ay;
                if (seg == 0) continue;
                xa = edge_col(ax, cx - ax, i, total);
                if (lower) xb = edge_col(bx, cx - bx, i - (by - ay), seg);
                else xb = edge_col(ax, bx - ax, i, seg);
                if (xa > xb) begin
                    tmp = xa; xa = xb; xb = tmp;
                end
                if (xa < 0) xa = 0;
                if (xb > w - 1) xb = w - 1;
                for (longint x = xa; x <= xb; x++)
                    shadow[row * DEF_MAX_WIDTH + x] = {c.red, c.green, c.blue};
            end
        endfunction

        // accepted command: update the shadow store and queue the result
        function void note_cmd(t_cmd c);
            t_rgb res;
            res = '0;
            case (c.func)
                FUNC_DRAW: fill_triangle(c);
                FUNC_READ: begin
                    res = shadow[c.row * DEF_MAX_WIDTH + c.col];
                    reads_seen++;
                end
                FUNC_CLEAR: foreach (shadow[k]) shadow[k] = '0;
                default: ;
            endcase
            pending = {pending, res};
        endfunction

        function void check_pix(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            t_rgb exp_px;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel result %02h %02h %02h", r, g, b);
                return;
            end
            exp_px = pending.pop_front();
            if ({r, g, b} !== exp_px) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch: expected %06h got %02h%02h%02h at %0t",
                             exp_px, r, g, b, $realtime);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    stf_cmd_if #(.COORD_BITS(CB)) cmd_ch ();
    stf_pix_if pix_ch ();
    stf_cfg_if cfg_ch ();

    scanline_triangle_fill_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_pix   (pix_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    pixel_scoreboard sb;
    int idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
    int quiet_cycles;
    int cmds_sent;
    int draws_sent;

    // clock
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // result side: check and stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.ready <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready)
                sb.check_pix(pix_ch.pixel_red, pix_ch.pixel_green, pix_ch.pixel_blue);
            if (idle_mode == 2) pix_ch.ready <= ($urandom_range(0, 99) >= 67);
            else if (idle_mode == 3) pix_ch.ready <= ($urandom_range(0, 99) >= 25);
            else pix_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no request moving
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_cmd(t_cmd c);
        int gap;
        cmd_ch.func        <= c.func;
        cmd_ch.vertex_a_x  <= c.ax;
        cmd_ch.vertex_a_y  <= c.ay;
        cmd_ch.vertex_b_x  <= c.bx;
        cmd_ch.vertex_b_y  <= c.by;
        cmd_ch.vertex_c_x  <= c.cx;
        cmd_ch.vertex_c_y  <= c.cy;
        cmd_ch.fill_red    <= c.red;
        cmd_ch.fill_green  <= c.green;
        cmd_ch.fill_blue   <= c.blue;
        cmd_ch.read_column <= c.col;
        cmd_ch.read_row    <= c.row;
        cmd_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_cmd(c);
        cmds_sent++;
        if (c.func == FUNC_DRAW) draws_sent++;
        gap = 0;
        if (idle_mode == 1) while ($urandom_range(0, 99) < 67) gap++;
        else if (idle_mode == 3) while ($urandom_range(0, 99) < 25) gap++;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_cmd make_cmd(logic [1:0] f, int ax, int ay, int bx, int by,
                                      int cx, int cy, logic [23:0] rgb,
                                      int col = 0, int row = 0);
        t_cmd c;
        c.func = f;
        c.ax = CB'(ax); c.ay = CB'(ay); c.bx = CB'(bx);
        c.by = CB'(by); c.cx = CB'(cx); c.cy = CB'(cy);
        {c.red, c.green, c.blue} = rgb;
        c.col = 7'(col); c.row = 6'(row);
        return c;
    endfunction

    function automatic t_cmd random_noise();
        t_cmd c;
        c.func = 2'($urandom_range(0, 3));
        if (c.func == FUNC_CLEAR && $urandom_range(0, 3) != 0) c.func = FUNC_READ;
        c.ax = CB'($urandom); c.ay = CB'($urandom); c.bx = CB'($urandom);
        c.by = CB'($urandom); c.cx = CB'($urandom); c.cy = CB'($urandom);
        c.red = 8'($urandom); c.green = 8'($urandom); c.blue = 8'($urandom);
        c.col = 7'($urandom); c.row = 6'($urandom);
        return c;
    endfunction

    // sorted triangle, mostly short so rows stay cheap
    function automatic t_cmd random_triangle();
        t_cmd c;
        int ay, dy;
        c = random_noise();
        c.func = FUNC_DRAW;
        ay = int'($urandom_range(0, 84)) - 10;
        dy = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 16);
        c.ay = CB'(ay);
        c.cy = CB'(ay + dy);
        c.by = CB'(ay + int'($urandom_range(0, dy)));
        c.ax = CB'(int'($urandom_range(0, 170)) - 20);
        c.bx = CB'(int'($urandom_range(0, 170)) - 20);
        c.cx = CB'(int'($urandom_range(0, 170)) - 20);
        return c;
    endfunction

    function automatic t_cmd random_item();
        t_cmd c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            c = random_triangle();
        end else if (pick < 87) begin
            c = random_noise();
            c.func = FUNC_READ;
        end else if (pick < 89) begin
            c = random_noise();
            c.func = FUNC_CLEAR;
        end else begin
            c = random_noise();
        end
        return c;
    endfunction

    initial begin
        sb = new();
        sb.reset_state();
        idle_mode = 0;
        cmds_sent = 0;
        draws_sent = 0;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.func = FUNC_READ;
        {cmd_ch.vertex_a_x, cmd_ch.vertex_a_y, cmd_ch.vertex_b_x} = '0;
        {cmd_ch.vertex_b_y, cmd_ch.vertex_c_x, cmd_ch.vertex_c_y} = '0;
        {cmd_ch.fill_red, cmd_ch.fill_green, cmd_ch.fill_blue} = '0;
        cmd_ch.read_column = '0;
        cmd_ch.read_row = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_FRAME_WIDTH;
        cfg_ch.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and corner cases
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 0, 0));
        send_cmd(make_cmd(FUNC_DRAW, -1024, -1024, 1023, 0, 0, 1023, 24'hffffff));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 127, 63));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 0, 0));
        send_cmd(make_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 24'h0));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 64, 32));
        // flat triangle
        send_cmd(make_cmd(FUNC_DRAW, 5, 10, 50, 10, 90, 10, 24'h123456));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 50, 10));
        // inverted triangle
        send_cmd(make_cmd(FUNC_DRAW, 5, 30, 50, 20, 90, 10, 24'h654321));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 50, 20));
        // flat top: upper half has zero height
        send_cmd(make_cmd(FUNC_DRAW, 10, 2, 60, 2, 30, 20, 24'hff0000));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 30, 5));
        // middle vertex below bottom: negative lower segment, swapped edges
        send_cmd(make_cmd(FUNC_DRAW, 100, 20, 0, 30, 20, 26, 24'h00ff00));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 60, 23));
        send_cmd(make_cmd(FUNC_DRAW, -30, 40, 200, 50, -5, 63, 24'h0000ff));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 10, 55));
        // unused command
        send_cmd(make_cmd(2'd3, 1023, 1023, -1, -1, 7, 7, 24'hffffff, 127, 63));
        send_cmd(make_cmd(FUNC_DRAW, 0, 0, 127, 0, 0, 1, 24'h000000));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 1, 0));
        send_cmd(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0, 24'h0, 127, 0));
        drain();

        // random phases, frame size swept between them
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_cfg(REG_FRAME_WIDTH, 8'd128); write_cfg(REG_FRAME_HEIGHT, 8'd64); end
                1: begin write_cfg(REG_FRAME_WIDTH, 8'd1);   write_cfg(REG_FRAME_HEIGHT, 8'd1);  end
                2: begin write_cfg(REG_FRAME_WIDTH, 8'd255); write_cfg(REG_FRAME_HEIGHT, 8'd127); end
                3: begin write_cfg(REG_FRAME_WIDTH, 8'd0);   write_cfg(REG_FRAME_HEIGHT, 8'd0);
                          write_cfg(4'd9, 8'hff); end
                default: begin write_cfg(REG_FRAME_WIDTH, 8'd77); write_cfg(REG_FRAME_HEIGHT, 8'd45); end
            endcase
            if (phase == 3) begin
                write_cfg(REG_FRAME_WIDTH, 8'd100);
                write_cfg(REG_FRAME_HEIGHT, 8'd40);
            end
            idle_mode = phase % 4;
            for (int n = 0; n < 54; n++) begin
                send_cmd(random_item());
                // hold off until everything in flight has returned
                if (phase == 1 && n == 27) begin
                    cmd_ch.valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("ran %0d commands (%0d draws, %0d reads) over five frame sizes",
                 cmds_sent, draws_sent, sb.reads_seen);
        $display("idling covered: none, sender, receiver, both");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
